// ===== hw/rtl/ekf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_pkg: shared definitions for the eased keyframe interpolator
// Widths, register and mode codes, divider request types and the sigmoid
// table, which is built at elaboration.
// ----------------------------------------------------------------------------
package ekf_pkg;

    // Field widths.
    localparam int CompW    = 16;
    localparam int AnchorW  = 3 * CompW;
    localparam int StepW    = 16;
    localparam int FactorW  = 17;
    localparam int SpeedW   = 8;
    localparam int CfgIdxW  = 3;
    localparam int SigDepth = 256;
    localparam int SigIdxW  = 9;

    // Divider geometry: quotient is always below 2^17.
    localparam int DivNumW = 41;
    localparam int DivDenW = 25;
    localparam int DivQW   = 17;
    localparam int DivCntW = 5;

    // Shared multiplier operand widths. The A side holds the Q32 fifth
    // power of the sine argument, which needs 35 bits.
    localparam int MulAW = 35;
    localparam int MulBW = 22;
    localparam int MulPW = MulAW + MulBW;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_TOTAL  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_EASE   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_END    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ASTART = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_AEND   = 3'd4;

    // Easing curve codes.
    localparam logic [2:0] EASE_LINEAR  = 3'd0;
    localparam logic [2:0] EASE_SIGMOID = 3'd1;
    localparam logic [2:0] EASE_CUBIC   = 3'd2;
    localparam logic [2:0] EASE_SINE    = 3'd3;
    localparam logic [2:0] EASE_INVERSE = 3'd4;
    localparam logic [2:0] EASE_RECIP   = 3'd5;

    // End-of-pass codes.
    localparam logic [1:0] END_STOP   = 2'd0;
    localparam logic [1:0] END_REPEAT = 2'd1;
    localparam logic [1:0] END_BOUNCE = 2'd2;

    // Curve constants.
    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [21:0] SINE_C3     = 22'd2796191;
    localparam logic [21:0] SINE_C5     = 22'd139805;
    localparam logic [16:0] RECIP_OFS   = 17'd89129;
    localparam logic [16:0] SINE_HALF3  = 17'd98304;

    typedef struct packed {
        logic               start;
        logic [DivNumW-1:0] num;
        logic [DivDenW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DivQW-1:0] quot;
    } t_div_rsp;

    typedef logic [FactorW-1:0] t_sig_rom [0:SigDepth];

    // Shift-and-subtract quotient, used only while the table is built.
    function automatic longint unsigned udiv64(input longint unsigned n,
                                               input longint unsigned d);
        longint unsigned q, rem;
        q   = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            if (rem >= d) begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Rounded logistic curve sampled at SigDepth+1 points, Q30 series exp.
    function automatic t_sig_rom sig_build();
        t_sig_rom          rom;
        longint unsigned   hi, mid, an, y, term, pos, neg, e, den, num;
        for (int i = 0; i <= SigDepth; i++) begin
            hi   = 64'(10 * i);
            mid  = 64'(5 * SigDepth);
            an   = (hi >= mid) ? hi - mid : mid - hi;
            y    = udiv64(an << 30, 64'(SigDepth)) >> 5;
            term = 64'd1 << 30;
            pos  = 64'd1 << 30;
            neg  = 64'd0;
            for (int k = 1; k <= 6; k++) begin
                term = udiv64((term * y) >> 30, 64'(k));
                if ((k & 1) == 1) neg = neg + term;
                else pos = pos + term;
            end
            e = pos - neg;
            for (int s = 0; s < 5; s++) e = (e * e) >> 30;
            den = (64'd1 << 30) + e;
            num = (hi >= mid) ? (64'd1 << 46) : (e << 16);
            rom[i] = FactorW'(udiv64(num + (den >> 1), den));
        end
        return rom;
    endfunction

    localparam t_sig_rom SIG_ROM = sig_build();

endpackage

// ===== hw/rtl/eased_keyframe_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eased_keyframe_interpolator: step counter, easing curve and anchor blend
// Advances a step counter per tick, eases the pass ratio and blends three
// signed Q8.8 components between two anchors.
// ----------------------------------------------------------------------------
// One tick is taken at a time. A tick that stops at the end of a pass gives
// its result in the next cycle. Otherwise the ratio divide runs first, then
// the curve (linear, sigmoid, sine, inverse and reciprocal, the last two
// with a second divide; the cubic code falls back to linear) and then the
// blend; a zero total skips the ratio divide. The bit-serial divider and
// the single shared multiplier serve these steps. The block takes no new
// tick until its result has been transferred. Configuration writes are
// always ready.
module eased_keyframe_interpolator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [ekf_pkg::SpeedW-1:0]       i_speed,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_updated,
    output logic [ekf_pkg::FactorW-1:0]      o_factor,
    output logic signed [ekf_pkg::CompW-1:0] o_out_x,
    output logic signed [ekf_pkg::CompW-1:0] o_out_y,
    output logic signed [ekf_pkg::CompW-1:0] o_out_z,
    output logic [ekf_pkg::StepW-1:0]        o_step_now,
    output logic                             o_reversed,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ekf_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [ekf_pkg::AnchorW-1:0]      i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDIV = 4'd1;
    localparam logic [3:0] S_EASE = 4'd2;
    localparam logic [3:0] S_SIG  = 4'd3;
    localparam logic [3:0] S_SN0  = 4'd4;
    localparam logic [3:0] S_SN1  = 4'd5;
    localparam logic [3:0] S_SN2  = 4'd6;
    localparam logic [3:0] S_SN3  = 4'd7;
    localparam logic [3:0] S_SN4  = 4'd8;
    localparam logic [3:0] S_SN5  = 4'd9;
    localparam logic [3:0] S_INV  = 4'd10;
    localparam logic [3:0] S_RC0  = 4'd11;
    localparam logic [3:0] S_EDIV = 4'd12;
    localparam logic [3:0] S_LERP = 4'd13;

    localparam int CW = ekf_pkg::CompW;
    localparam int FW = ekf_pkg::FactorW;

    // Configuration registers.
    logic [ekf_pkg::StepW-1:0]   r_total;
    logic [2:0]                  r_ease;
    logic [1:0]                  r_end;
    logic [ekf_pkg::AnchorW-1:0] r_astart, r_aend;

    // Sequencer and working registers.
    logic [3:0]                  r_state, n_state;
    logic [ekf_pkg::StepW-1:0]   r_step, n_step;
    logic                        r_rev, n_rev;
    logic [ekf_pkg::StepW-1:0]   r_st, n_st;
    logic [FW-1:0]               r_x, n_x;
    logic [FW-1:0]               r_t, n_t;
    logic [16:0]                 r_sa, n_sa;
    logic                        r_neg, n_neg;
    logic [33:0]                 r_sa2, n_sa2;
    logic [33:0]                 r_sa3, n_sa3;
    logic [34:0]                 r_sa5, n_sa5;
    logic [57:0]                 r_acc, n_acc;
    logic [2:0]                  r_lc, n_lc;
    ekf_pkg::t_div_req           r_dreq, n_dreq;
    ekf_pkg::t_div_rsp           dv_rsp;

    // Result register.
    logic                        r_out_valid, n_out_valid;
    logic                        r_o_upd, n_o_upd;
    logic [FW-1:0]               r_o_fac, n_o_fac;
    logic [CW-1:0]               r_o_c [0:2];
    logic [CW-1:0]               n_o_c [0:2];
    logic [ekf_pkg::StepW-1:0]   r_o_step, n_o_step;
    logic                        r_o_rev, n_o_rev;

    // Shared multiplier.
    logic [ekf_pkg::MulAW-1:0]   mul_a;
    logic [ekf_pkg::MulBW-1:0]   mul_b;
    logic [ekf_pkg::MulPW-1:0]   mul_p;

    logic                        in_xfer, out_xfer, cfg_xfer;
    logic [16:0]                 st_sum;
    logic [CW-1:0]               s_off, e_off;
    logic [1:0]                  comp;
    logic [ekf_pkg::AnchorW-1:0] a_lo, a_hi;
    logic [FW-1:0]               omt;
    logic [ekf_pkg::SigIdxW-1:0] sk;
    logic [FW-1:0]               sig_a, sig_b, sig_d;
    logic [17:0]                 x3;
    logic [57:0]                 sn_p;
    logic [17:0]                 sn_pr;
    logic [17:0]                 inv_den;
    logic [24:0]                 rc_den;
    logic [32:0]                 lerp_sum;

    function automatic logic [FW-1:0] clamp_one(input logic [17:0] v);
        return (v > 18'(ekf_pkg::ONE_Q16)) ? ekf_pkg::ONE_Q16 : v[FW-1:0];
    endfunction

    assign in_xfer     = i_valid && o_ready;
    assign out_xfer    = r_out_valid && i_ready;
    assign cfg_xfer    = i_cfg_valid;
    assign o_ready     = (r_state == S_IDLE) && !r_out_valid;
    assign o_cfg_ready = 1'b1;

    ekf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (dv_rsp)
    );

    // Anchors after the bounce swap, offset to unsigned for the blend.
    assign a_lo  = r_rev ? r_aend : r_astart;
    assign a_hi  = r_rev ? r_astart : r_aend;
    assign comp  = r_lc[2:1];
    assign s_off = a_lo[comp*CW +: CW] ^ {1'b1, {(CW-1){1'b0}}};
    assign e_off = a_hi[comp*CW +: CW] ^ {1'b1, {(CW-1){1'b0}}};
    assign omt   = ekf_pkg::ONE_Q16 - r_t;

    // Sigmoid table lookup around the current ratio.
    assign sk    = {1'b0, r_x[15:8]};
    assign sig_a = ekf_pkg::SIG_ROM[sk];
    assign sig_b = ekf_pkg::SIG_ROM[sk + 1'b1];
    assign sig_d = (sig_b >= sig_a) ? sig_b - sig_a : '0;

    // Multiplier operand selection by sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SIG: begin
                mul_a = ekf_pkg::MulAW'(sig_d);
                mul_b = ekf_pkg::MulBW'({r_x[7:0], 8'h00});
            end
            S_SN1: begin
                mul_a = ekf_pkg::MulAW'(r_sa);
                mul_b = ekf_pkg::MulBW'(r_sa);
            end
            S_SN2: begin
                mul_a = ekf_pkg::MulAW'(r_sa2);
                mul_b = ekf_pkg::MulBW'(r_sa);
            end
            S_SN3: begin
                mul_a = ekf_pkg::MulAW'(r_sa3);
                mul_b = ekf_pkg::MulBW'(r_sa2[33:16]);
            end
            S_SN4: begin
                mul_a = ekf_pkg::MulAW'(r_sa5);
                mul_b = ekf_pkg::SINE_C5;
            end
            S_SN5: begin
                mul_a = ekf_pkg::MulAW'(r_sa3);
                mul_b = ekf_pkg::SINE_C3;
            end
            S_RC0: begin
                mul_a = ekf_pkg::MulAW'(r_x);
                mul_b = ekf_pkg::MulBW'(200);
            end
            S_LERP: begin
                if (!r_lc[0]) begin
                    mul_a = ekf_pkg::MulAW'(s_off);
                    mul_b = ekf_pkg::MulBW'(omt);
                end else begin
                    mul_a = ekf_pkg::MulAW'(e_off);
                    mul_b = ekf_pkg::MulBW'(r_t);
                end
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Datapath helpers for the individual steps.
    assign st_sum   = {1'b0, r_step} + 17'(i_speed);
    assign x3       = 18'(r_x) + 18'(r_x) + 18'(r_x);
    assign sn_p     = (r_acc > 58'(mul_p)) ? r_acc - 58'(mul_p) : '0;
    assign sn_pr    = 18'((sn_p + (58'd1 << 40)) >> 41);
    assign inv_den  = 18'd131072 - 18'(r_x);
    assign rc_den   = 25'(mul_p[24:0]) + 25'd4849664;
    assign lerp_sum = 33'(r_acc) + 33'(mul_p[31:0]) + 33'd32768;

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rev       = r_rev;
        n_st        = r_st;
        n_x         = r_x;
        n_t         = r_t;
        n_sa        = r_sa;
        n_neg       = r_neg;
        n_sa2       = r_sa2;
        n_sa3       = r_sa3;
        n_sa5       = r_sa5;
        n_acc       = r_acc;
        n_lc        = r_lc;
        n_dreq      = r_dreq;
        n_dreq.start = 1'b0;
        n_out_valid = r_out_valid && !out_xfer;
        n_o_upd     = r_o_upd;
        n_o_fac     = r_o_fac;
        n_o_c       = r_o_c;
        n_o_step    = r_o_step;
        n_o_rev     = r_o_rev;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if ((st_sum >= {1'b0, r_total}) && r_end != ekf_pkg::END_REPEAT
                            && r_end != ekf_pkg::END_BOUNCE) begin
                        // Stopped at the end of the pass.
                        n_step      = r_total;
                        n_out_valid = 1'b1;
                        n_o_upd     = 1'b0;
                        n_o_fac     = '0;
                        n_o_c[0]    = '0;
                        n_o_c[1]    = '0;
                        n_o_c[2]    = '0;
                        n_o_step    = r_total;
                        n_o_rev     = r_rev;
                    end else begin
                        if (st_sum >= {1'b0, r_total}) begin
                            n_st = '0;
                            if (r_end == ekf_pkg::END_BOUNCE) n_rev = !r_rev;
                        end else begin
                            n_st = st_sum[15:0];
                        end
                        n_step = n_st;
                        if (r_total == '0) begin
                            n_x     = '0;
                            n_state = S_EASE;
                        end else begin
                            n_dreq.start = 1'b1;
                            n_dreq.num   = ekf_pkg::DivNumW'({n_st, 16'h0000});
                            n_dreq.den   = ekf_pkg::DivDenW'(r_total);
                            n_state      = S_RDIV;
                        end
                    end
                end
            end
            S_RDIV: begin
                if (dv_rsp.done) begin
                    n_x     = dv_rsp.quot;
                    n_state = S_EASE;
                end
            end
            S_EASE: begin
                case (r_ease)
                    ekf_pkg::EASE_SIGMOID: n_state = S_SIG;
                    ekf_pkg::EASE_SINE:    n_state = S_SN0;
                    ekf_pkg::EASE_INVERSE: n_state = S_INV;
                    ekf_pkg::EASE_RECIP:   n_state = S_RC0;
                    default: begin
                        n_t     = clamp_one(18'(r_x));
                        n_acc   = '0;
                        n_lc    = '0;
                        n_state = S_LERP;
                    end
                endcase
            end
            S_SIG: begin
                if (r_x >= ekf_pkg::ONE_Q16) begin
                    n_t = clamp_one(18'(ekf_pkg::SIG_ROM[ekf_pkg::SigDepth]));
                end else begin
                    n_t = clamp_one(18'(sig_a) + 18'((mul_p[32:0] + 33'd32768) >> 16));
                end
                n_lc    = '0;
                n_state = S_LERP;
            end
            S_SN0: begin
                n_neg   = x3 < 18'(ekf_pkg::SINE_HALF3);
                n_sa    = (x3 < 18'(ekf_pkg::SINE_HALF3))
                          ? 17'(18'(ekf_pkg::SINE_HALF3) - x3)
                          : 17'(x3 - 18'(ekf_pkg::SINE_HALF3));
                n_state = S_SN1;
            end
            S_SN1: begin
                n_sa2   = mul_p[33:0];
                n_state = S_SN2;
            end
            S_SN2: begin
                n_sa3   = mul_p[49:16];
                n_state = S_SN3;
            end
            S_SN3: begin
                n_sa5   = mul_p[50:16];
                n_state = S_SN4;
            end
            S_SN4: begin
                n_acc   = ({41'd0, r_sa} << 40) + 58'(mul_p[52:0]);
                n_state = S_SN5;
            end
            S_SN5: begin
                if (r_neg) begin
                    n_t = (sn_pr >= 18'd32768) ? '0 : FW'(18'd32768 - sn_pr);
                end else begin
                    n_t = clamp_one(18'd32768 + sn_pr);
                end
                n_lc    = '0;
                n_state = S_LERP;
            end
            S_INV: begin
                n_dreq.start = 1'b1;
                n_dreq.num   = ekf_pkg::DivNumW'(({18'd0, r_x} << 16) + 35'(inv_den >> 1));
                n_dreq.den   = ekf_pkg::DivDenW'(inv_den);
                n_state      = S_EDIV;
            end
            S_RC0: begin
                n_dreq.start = 1'b1;
                n_dreq.num   = ekf_pkg::DivNumW'(41'd429496729600 + 41'(rc_den >> 1));
                n_dreq.den   = rc_den;
                n_state      = S_EDIV;
            end
            S_EDIV: begin
                if (dv_rsp.done) begin
                    if (r_ease == ekf_pkg::EASE_RECIP) begin
                        n_t = (dv_rsp.quot > ekf_pkg::RECIP_OFS) ? '0
                              : clamp_one(18'(ekf_pkg::RECIP_OFS - dv_rsp.quot));
                    end else begin
                        n_t = clamp_one(18'(dv_rsp.quot));
                    end
                    n_lc    = '0;
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                // Even steps weigh the start anchor, odd steps add the end anchor.
                if (!r_lc[0]) begin
                    n_acc = 58'(mul_p[32:0]);
                end else begin
                    n_o_c[comp] = lerp_sum[31:16] ^ {1'b1, {(CW-1){1'b0}}};
                end
                n_lc = r_lc + 1'b1;
                if (r_lc == 3'd5) begin
                    n_out_valid = 1'b1;
                    n_o_upd     = 1'b1;
                    n_o_fac     = r_t;
                    n_o_step    = r_st;
                    n_o_rev     = r_rev;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // A total-steps write restarts the pass.
        if (cfg_xfer && i_cfg_index == ekf_pkg::CFG_TOTAL) n_step = '0;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= ekf_pkg::StepW'(1);
            r_ease   <= ekf_pkg::EASE_LINEAR;
            r_end    <= ekf_pkg::END_STOP;
            r_astart <= '0;
            r_aend   <= '0;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                ekf_pkg::CFG_TOTAL:  r_total  <= i_cfg_data[ekf_pkg::StepW-1:0];
                ekf_pkg::CFG_EASE:   r_ease   <= i_cfg_data[2:0];
                ekf_pkg::CFG_END:    r_end    <= i_cfg_data[1:0];
                ekf_pkg::CFG_ASTART: r_astart <= i_cfg_data;
                ekf_pkg::CFG_AEND:   r_aend   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_rev        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_dreq.start <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_rev        <= n_rev;
            r_out_valid  <= n_out_valid;
            r_dreq.start <= n_dreq.start;
        end
        r_dreq.num <= n_dreq.num;
        r_dreq.den <= n_dreq.den;
        r_st       <= n_st;
        r_x        <= n_x;
        r_t        <= n_t;
        r_sa       <= n_sa;
        r_neg      <= n_neg;
        r_sa2      <= n_sa2;
        r_sa3      <= n_sa3;
        r_sa5      <= n_sa5;
        r_acc      <= n_acc;
        r_lc       <= n_lc;
        r_o_upd    <= n_o_upd;
        r_o_fac    <= n_o_fac;
        r_o_c      <= n_o_c;
        r_o_step   <= n_o_step;
        r_o_rev    <= n_o_rev;
    end

    assign o_valid    = r_out_valid;
    assign o_updated  = r_o_upd;
    assign o_factor   = r_o_fac;
    assign o_out_x    = r_o_c[0];
    assign o_out_y    = r_o_c[1];
    assign o_out_z    = r_o_c[2];
    assign o_step_now = r_o_step;
    assign o_reversed = r_o_rev;

endmodule

// ===== hw/rtl/ekf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_div: iterative restoring divider
// Produces a 17-bit quotient one bit per cycle. The caller guarantees that
// the quotient fits, so the upper numerator bits start as the remainder.
// ----------------------------------------------------------------------------
module ekf_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ekf_pkg::t_div_req i_req,
    output ekf_pkg::t_div_rsp o_rsp
);

    logic [ekf_pkg::DivDenW-1:0] r_rem, n_rem;
    logic [ekf_pkg::DivQW-1:0]   r_lo, n_lo;
    logic [ekf_pkg::DivQW-1:0]   r_q, n_q;
    logic [ekf_pkg::DivDenW-1:0] r_den, n_den;
    logic [ekf_pkg::DivCntW-1:0] r_cnt, n_cnt;
    logic                        r_done, n_done;
    logic [ekf_pkg::DivDenW:0]   trial;
    logic [ekf_pkg::DivDenW:0]   diff;

    // One trial subtraction per cycle.
    always_comb begin
        trial  = {r_rem, r_lo[ekf_pkg::DivQW-1]};
        diff   = trial - {1'b0, r_den};
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_q    = r_q;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_rem = ekf_pkg::DivDenW'(i_req.num[ekf_pkg::DivNumW-1:ekf_pkg::DivQW]);
            n_lo  = i_req.num[ekf_pkg::DivQW-1:0];
            n_den = i_req.den;
            n_q   = '0;
            n_cnt = ekf_pkg::DivCntW'(ekf_pkg::DivQW);
        end else if (r_cnt != '0) begin
            if (!diff[ekf_pkg::DivDenW]) begin
                n_rem = diff[ekf_pkg::DivDenW-1:0];
                n_q   = {r_q[ekf_pkg::DivQW-2:0], 1'b1};
            end else begin
                n_rem = trial[ekf_pkg::DivDenW-1:0];
                n_q   = {r_q[ekf_pkg::DivQW-2:0], 1'b0};
            end
            n_lo   = {r_lo[ekf_pkg::DivQW-2:0], 1'b0};
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == ekf_pkg::DivCntW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_q   <= n_q;
        r_den <= n_den;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== hw/rtl/ekf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ekf_checker: port-level checks for the eased keyframe interpolator
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module ekf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic                             o_updated,
    input logic [ekf_pkg::FactorW-1:0]      o_factor,
    input logic signed [ekf_pkg::CompW-1:0] o_out_x,
    input logic signed [ekf_pkg::CompW-1:0] o_out_y,
    input logic signed [ekf_pkg::CompW-1:0] o_out_z
);

    // A stopped result carries a zero factor and zero components.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_updated) |->
            (o_factor == '0 && o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("stopped result carries nonzero data");

    // The eased factor never exceeds one.
    a_factor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_factor <= ekf_pkg::ONE_Q16))
        else $error("factor above one");

    // One tick at a time: no ready right after a tick transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second tick accepted while busy");

    // A waiting result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_factor) && $stable(o_updated)))
        else $error("pending result changed");

    // Reset leaves no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind eased_keyframe_interpolator ekf_checker u_ekf_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_updated (o_updated),
    .o_factor  (o_factor),
    .o_out_x   (o_out_x),
    .o_out_y   (o_out_y),
    .o_out_z   (o_out_z)
);
